// ===== rtl/frame_size_change_upload_decider_core_macros.svh =====
// Assertion macros shared by the frame size change upload decider RTL.
`ifndef FRAME_SIZE_CHANGE_UPLOAD_DECIDER_CORE_MACROS_SVH
`define FRAME_SIZE_CHANGE_UPLOAD_DECIDER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FSCUD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fscud: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FSCUD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fscud: next-cycle check failed");

`endif

// ===== rtl/fscud_pkg.sv =====
// Package: widths, codes and reset values of the frame size change upload decider.
package fscud_pkg;

    // window depth
    localparam int WINDOW_SIZE = 8;

    // field widths
    localparam int SIZE_W   = 20;
    localparam int TIME_W   = 32;
    localparam int THR_W    = 16;
    localparam int AVG_W    = 24;
    localparam int RATIO_W  = 16;
    localparam int REASON_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // derived window widths
    localparam int SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FILL_W = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = SIZE_W + $clog2(WINDOW_SIZE);

    // reason codes
    localparam logic [REASON_W-1:0] REASON_NONE     = 2'd0;
    localparam logic [REASON_W-1:0] REASON_FIRST    = 2'd1;
    localparam logic [REASON_W-1:0] REASON_CHANGE   = 2'd2;
    localparam logic [REASON_W-1:0] REASON_INTERVAL = 2'd3;

    // item kinds
    localparam logic KIND_FRAME       = 1'b0;
    localparam logic KIND_UPLOAD_DONE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_AVG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE     = 2'd3;

    // register reset values
    localparam logic [SIZE_W-1:0] MIN_AVG_RST   = 20'd1000;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 16'd77;
    localparam logic [TIME_W-1:0] COOLDOWN_RST  = 32'd2000;
    localparam logic [TIME_W-1:0] FORCE_RST     = 32'd10000;

endpackage

// ===== rtl/fscud_frame_if.sv =====
// Interface: frame and upload-done items into the decider.
interface fscud_frame_if;
    import fscud_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [SIZE_W-1:0] frame_size;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output kind, output frame_size, output now_ms,
                    input ready);
    modport sink   (input valid, input kind, input frame_size, input now_ms,
                    output ready);
endinterface

// ===== rtl/fscud_result_if.sv =====
// Interface: decision items out of the decider.
interface fscud_result_if;
    import fscud_pkg::*;

    logic                valid;
    logic                ready;
    logic                upload_now;
    logic [REASON_W-1:0] reason_code;
    logic [AVG_W-1:0]    average_size_q4;
    logic [RATIO_W-1:0]  change_ratio_q8;
    logic                window_full;
    logic                cooling_down;
    logic                change_triggered;
    logic                interval_triggered;

    modport source (output valid, output upload_now, output reason_code,
                    output average_size_q4, output change_ratio_q8, output window_full,
                    output cooling_down, output change_triggered,
                    output interval_triggered, input ready);
    modport sink   (input valid, input upload_now, input reason_code,
                    input average_size_q4, input change_ratio_q8, input window_full,
                    input cooling_down, input change_triggered,
                    input interval_triggered, output ready);
endinterface

// ===== rtl/frame_size_change_upload_decider_core.sv =====
// Top level: frame size change upload decider with a shared serial divider.
// Sequence: a frame item passes PREP, DIFF, JUDGE, DIVA, DIVR and DONE before
// its result shows; an upload-done item is absorbed in IDLE and gives none.
// Items are taken only in IDLE; the restoring divider retires one quotient bit
// a cycle (27 bits of mean, then 16 bits of ratio), shared by both divisions.
// Reset: rst_n clears window, running sum, fill, slot, upload history; registers take reset values.
`include "frame_size_change_upload_decider_core_macros.svh"

module frame_size_change_upload_decider_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [fscud_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fscud_pkg::CFG_DATA_W-1:0] cfg_wdata,
    fscud_frame_if.sink                    frames,
    fscud_result_if.source                 results
);
    import fscud_pkg::*;

    // derived datapath widths
    localparam int AVG_N_W  = SUM_W + 4;
    localparam int CNT_W    = $clog2(AVG_N_W + 1);
    localparam int THRP_W   = THR_W + SUM_W;
    localparam int MINP_W   = SIZE_W + FILL_W;
    localparam int SCALED_W = SIZE_W + FILL_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_DIFF  = 3'd2;
    localparam logic [2:0] S_JUDGE = 3'd3;
    localparam logic [2:0] S_DIVA  = 3'd4;
    localparam logic [2:0] S_DIVR  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // control and architectural state
    logic [2:0]         state_reg, state_next;
    logic [SIZE_W-1:0]  min_avg_reg;
    logic [THR_W-1:0]   threshold_reg;
    logic [TIME_W-1:0]  cooldown_reg;
    logic [TIME_W-1:0]  force_reg;
    logic [SIZE_W-1:0]  win_reg [WINDOW_SIZE];
    logic [SUM_W-1:0]   sum_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [TIME_W-1:0]  last_upload_reg;
    logic               ever_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // datapath registers
    logic [SIZE_W-1:0]   size_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [SCALED_W-1:0] scaled_reg;
    logic [THRP_W-1:0]   thr_prod_reg;
    logic [MINP_W-1:0]   min_prod_reg;
    logic                cooling_reg;
    logic                interval_reg;
    logic [SUM_W-1:0]    diff_reg;
    logic                change_reg;
    logic                sat_reg;
    logic [AVG_W-1:0]    avg_reg;
    logic [SUM_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    divisor_reg;
    logic [AVG_N_W-1:0]  dvd_reg;
    logic [AVG_N_W-1:0]  quo_reg;

    // output registers
    logic                out_upload_reg;
    logic [REASON_W-1:0] out_reason_reg;
    logic [AVG_W-1:0]    out_avg_reg;
    logic [RATIO_W-1:0]  out_ratio_reg;
    logic                out_full_reg;
    logic                out_cooling_reg;
    logic                out_change_reg;
    logic                out_interval_reg;

    // handshakes
    logic frame_acc;
    logic done_go;
    logic full;
    logic [TIME_W-1:0] elapsed;

    assign frames.ready = (state_reg == S_IDLE);
    assign frame_acc    = frames.valid && frames.ready;
    assign done_go      = (state_reg == S_DONE) && (!out_valid_reg || results.ready);
    assign full         = (fill_reg >= FILL_W'(WINDOW_SIZE));
    assign elapsed      = now_reg - last_upload_reg;

    // shared restoring divider step: one quotient bit per cycle
    logic [SUM_W:0]     div_shift;
    logic               div_ge;
    logic [SUM_W:0]     div_sub;
    logic [SUM_W-1:0]   rem_step;
    logic [AVG_N_W-1:0] quo_step;

    assign div_shift = {rem_reg, dvd_reg[AVG_N_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_sub   = div_shift - {1'b0, divisor_reg};
    assign rem_step  = div_ge ? div_sub[SUM_W-1:0] : div_shift[SUM_W-1:0];
    assign quo_step  = {quo_reg[AVG_N_W-2:0], div_ge};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (frame_acc && frames.kind == KIND_FRAME)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:  state_next = S_DIFF;
            S_DIFF:  state_next = S_JUDGE;
            S_JUDGE: state_next = S_DIVA;
            S_DIVA:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DIVR;
                end
            end
            S_DIVR:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // decision from the judged flags
    logic                upload_dec;
    logic [REASON_W-1:0] reason_dec;

    always_comb
    begin
        if (!ever_reg)
        begin
            upload_dec = 1'b1;
            reason_dec = REASON_FIRST;
        end
        else if (change_reg && !cooling_reg)
        begin
            upload_dec = 1'b1;
            reason_dec = REASON_CHANGE;
        end
        else if (interval_reg)
        begin
            upload_dec = 1'b1;
            reason_dec = REASON_INTERVAL;
        end
        else
        begin
            upload_dec = 1'b0;
            reason_dec = REASON_NONE;
        end
    end

    // control, registers and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            min_avg_reg     <= MIN_AVG_RST;
            threshold_reg   <= THRESHOLD_RST;
            cooldown_reg    <= COOLDOWN_RST;
            force_reg       <= FORCE_RST;
            for (int i = 0; i < WINDOW_SIZE; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg         <= '0;
            fill_reg        <= '0;
            slot_reg        <= '0;
            last_upload_reg <= '0;
            ever_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_AVG:   min_avg_reg   <= cfg_wdata[SIZE_W-1:0];
                    CFG_THRESHOLD: threshold_reg <= cfg_wdata[THR_W-1:0];
                    CFG_COOLDOWN:  cooldown_reg  <= cfg_wdata[TIME_W-1:0];
                    CFG_FORCE:     force_reg     <= cfg_wdata[TIME_W-1:0];
                    default:       ;
                endcase
            end

            // upload-done item records the time
            if (frame_acc && frames.kind == KIND_UPLOAD_DONE)
            begin
                last_upload_reg <= frames.now_ms;
                ever_reg        <= 1'b1;
            end

            // divider step counter
            if (state_reg == S_JUDGE)
            begin
                cnt_reg <= CNT_W'(AVG_N_W);
            end
            else if (state_reg == S_DIVA && cnt_reg == CNT_W'(1))
            begin
                cnt_reg <= CNT_W'(RATIO_W);
            end
            else if (state_reg == S_DIVA || state_reg == S_DIVR)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end

            // result out, window update
            if (results.valid && results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (done_go)
            begin
                out_valid_reg     <= 1'b1;
                sum_reg           <= sum_reg - win_reg[slot_reg] + SUM_W'(size_reg);
                win_reg[slot_reg] <= size_reg;
                slot_reg          <= (slot_reg == SLOT_W'(WINDOW_SIZE - 1)) ? '0
                                     : slot_reg + SLOT_W'(1);
                if (!full)
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (frame_acc)
                begin
                    size_reg <= frames.frame_size;
                    now_reg  <= frames.now_ms;
                end
            end
            S_PREP:
            begin
                scaled_reg   <= SCALED_W'(size_reg) * SCALED_W'(fill_reg);
                thr_prod_reg <= THRP_W'(threshold_reg) * THRP_W'(sum_reg);
                min_prod_reg <= MINP_W'(min_avg_reg) * MINP_W'(fill_reg);
                cooling_reg  <= ever_reg && (elapsed < cooldown_reg);
                interval_reg <= ever_reg && (elapsed >= force_reg);
            end
            S_DIFF:
            begin
                diff_reg <= (scaled_reg >= SCALED_W'(sum_reg))
                            ? SUM_W'(scaled_reg - SCALED_W'(sum_reg))
                            : SUM_W'(SCALED_W'(sum_reg) - scaled_reg);
            end
            S_JUDGE:
            begin
                change_reg  <= full && (sum_reg != '0)
                               && (MINP_W'(sum_reg) >= min_prod_reg)
                               && (THRP_W'({diff_reg, 8'd0}) > thr_prod_reg);
                sat_reg     <= ({8'd0, diff_reg} >= {sum_reg, 8'd0});
                // mean: 16 * sum / fill
                rem_reg     <= '0;
                divisor_reg <= SUM_W'(fill_reg);
                dvd_reg     <= {sum_reg, 4'd0};
                quo_reg     <= '0;
            end
            S_DIVA:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    avg_reg     <= (fill_reg == '0) ? '0 : quo_step[AVG_W-1:0];
                    // ratio: 256 * diff / sum, upper bits preloaded as remainder
                    rem_reg     <= SUM_W'(diff_reg[SUM_W-1:8]);
                    divisor_reg <= sum_reg;
                    dvd_reg     <= {diff_reg[7:0], 8'd0, (AVG_N_W - 16)'(0)};
                    quo_reg     <= '0;
                end
                else
                begin
                    rem_reg <= rem_step;
                    dvd_reg <= {dvd_reg[AVG_N_W-2:0], 1'b0};
                    quo_reg <= quo_step;
                end
            end
            S_DIVR:
            begin
                rem_reg <= rem_step;
                dvd_reg <= {dvd_reg[AVG_N_W-2:0], 1'b0};
                quo_reg <= quo_step;
            end
            S_DONE:
            begin
                if (done_go)
                begin
                    out_upload_reg   <= upload_dec;
                    out_reason_reg   <= reason_dec;
                    out_avg_reg      <= avg_reg;
                    out_ratio_reg    <= (sum_reg == '0) ? '0
                                        : (sat_reg ? '1 : quo_reg[RATIO_W-1:0]);
                    out_full_reg     <= full;
                    out_cooling_reg  <= cooling_reg;
                    out_change_reg   <= change_reg;
                    out_interval_reg <= interval_reg;
                end
            end
            default: ;
        endcase
    end

    // result channel
    assign results.valid              = out_valid_reg;
    assign results.upload_now         = out_upload_reg;
    assign results.reason_code        = out_reason_reg;
    assign results.average_size_q4    = out_avg_reg;
    assign results.change_ratio_q8    = out_ratio_reg;
    assign results.window_full        = out_full_reg;
    assign results.cooling_down       = out_cooling_reg;
    assign results.change_triggered   = out_change_reg;
    assign results.interval_triggered = out_interval_reg;

    // checks
    `FSCUD_ASSERT_NEXT(a_done_records, frame_acc && frames.kind == KIND_UPLOAD_DONE, ever_reg)
    `FSCUD_ASSERT_NEXT(a_frame_busy, frame_acc && frames.kind == KIND_FRAME, !frames.ready)
    `FSCUD_ASSERT_NEXT(a_done_shows, done_go, results.valid)
    `FSCUD_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(WINDOW_SIZE))
    `FSCUD_ASSERT_NOW(a_change_reason, results.valid && results.reason_code == REASON_CHANGE,
                      results.change_triggered && !results.cooling_down)

endmodule

// ===== test/frame_size_change_upload_decider_core_tb.sv =====
// Testbench: upload decider driven with directed and random items, decisions checked by a model.
module frame_size_change_upload_decider_core_tb;
    import fscud_pkg::*;

    localparam int     RESET_CYCLES = 5;
    localparam int     SETTLE       = 64;
    localparam int     HOLD_CYCLES  = 2500;
    localparam int     PHASES       = 10;
    localparam int     PHASE_ITEMS  = 190;
    localparam longint CYCLE_LIMIT  = 3000000;

    // one decision item, field order as on the result interface
    typedef struct packed {
        logic                upload_now;
        logic [REASON_W-1:0] reason_code;
        logic [AVG_W-1:0]    average_size_q4;
        logic [RATIO_W-1:0]  change_ratio_q8;
        logic                window_full;
        logic                cooling_down;
        logic                change_triggered;
        logic                interval_triggered;
    } decision_t;

    // directed row; want is used only when pinned
    typedef struct {
        logic              kind;
        logic [SIZE_W-1:0] size;
        logic [TIME_W-1:0] now;
        bit                pinned;
        decision_t         want;
    } probe_t;

    typedef enum int { SIZES_ANY, SIZES_ZERO, SIZES_STEADY, SIZES_SPIKY } size_mix_t;

    // register values and traffic shape of one random phase
    typedef struct {
        logic [SIZE_W-1:0] min_avg;
        logic [THR_W-1:0]  threshold;
        logic [TIME_W-1:0] cooldown;
        logic [TIME_W-1:0] force_ms;
        bit                shuffle;
        bit                quiet;
        bit                hold;
        size_mix_t         mix;
    } setting_t;

    // first frame after reset: nothing stored, or only zero sizes
    localparam decision_t FIRST_ON_EMPTY = '{1'b1, REASON_FIRST, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0};
    localparam decision_t UNPINNED       = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    fscud_frame_if  frame_bus ();
    fscud_result_if decision_bus ();

    frame_size_change_upload_decider_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .frames    (frame_bus),
        .results   (decision_bus)
    );

    always #5 clk = ~clk;

    // decider model state
    logic [SIZE_W-1:0] win_sizes [WINDOW_SIZE];
    logic [63:0]       win_sum;
    int unsigned       win_fill;
    int unsigned       win_slot;
    logic [TIME_W-1:0] last_upload;
    bit                uploaded;
    logic [SIZE_W-1:0] reg_min_avg;
    logic [THR_W-1:0]  reg_threshold;
    logic [TIME_W-1:0] reg_cooldown;
    logic [TIME_W-1:0] reg_force;

    decision_t   owed[$];
    int unsigned mismatches;
    longint      cycles;
    bit          quiet;
    bit          hold_off_req;
    bit          upload_told;

    // judge one frame against the window, then push its size into the window
    function automatic decision_t judge_frame(logic [SIZE_W-1:0] size, logic [TIME_W-1:0] now);
        decision_t         d;
        logic [63:0]       fill;
        logic [63:0]       scaled;
        logic [63:0]       diff;
        logic [63:0]       ratio;
        logic [TIME_W-1:0] elapsed;
        d = '0;
        fill = 64'(win_fill);
        if (fill != 0)
            d.average_size_q4 = AVG_W'((win_sum * 16) / fill);
        scaled = 64'(size) * fill;
        diff = (scaled >= win_sum) ? scaled - win_sum : win_sum - scaled;
        if (win_sum != 0)
        begin
            ratio = (diff * 256) / win_sum;
            d.change_ratio_q8 = (ratio > 65535) ? 16'hFFFF : RATIO_W'(ratio);
        end
        elapsed = now - last_upload;    // wraps mod 2^32
        d.window_full        = (fill >= WINDOW_SIZE);
        d.cooling_down       = uploaded && (elapsed < reg_cooldown);
        d.interval_triggered = uploaded && (elapsed >= reg_force);
        d.change_triggered   = d.window_full && (win_sum != 0)
            && (win_sum >= 64'(reg_min_avg) * fill)
            && (diff * 256 > 64'(reg_threshold) * win_sum);

        // priority: first, change out of cooldown, interval
        if (!uploaded)
        begin
            d.upload_now  = 1'b1;
            d.reason_code = REASON_FIRST;
        end
        else if (d.change_triggered && !d.cooling_down)
        begin
            d.upload_now  = 1'b1;
            d.reason_code = REASON_CHANGE;
        end
        else if (d.interval_triggered)
        begin
            d.upload_now  = 1'b1;
            d.reason_code = REASON_INTERVAL;
        end
        else
        begin
            d.upload_now  = 1'b0;
            d.reason_code = REASON_NONE;
        end

        win_sum = win_sum - 64'(win_sizes[win_slot]) + 64'(size);
        win_sizes[win_slot] = size;
        win_slot = (win_slot + 1) % WINDOW_SIZE;
        if (win_fill < WINDOW_SIZE)
            win_fill++;
        return d;
    endfunction

    function automatic string describe(decision_t d);
        return $sformatf("up=%0d reason=%0d avg_q4=%0d ratio_q8=%0d full=%0d cool=%0d chg=%0d int=%0d",
                         d.upload_now, d.reason_code, d.average_size_q4, d.change_ratio_q8,
                         d.window_full, d.cooling_down, d.change_triggered, d.interval_triggered);
    endfunction

    // mostly short idle stretches, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 16);
        return $urandom_range(30, 200);
    endfunction

    function automatic int unsigned sender_gap();
        if (quiet || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // write one register and mirror it; cfg_we is lowered by the caller
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            CFG_MIN_AVG:   reg_min_avg   = data[SIZE_W-1:0];
            CFG_THRESHOLD: reg_threshold = data[THR_W-1:0];
            CFG_COOLDOWN:  reg_cooldown  = data;
            CFG_FORCE:     reg_force     = data;
        endcase
    endtask

    // junk in the unused upper bits must be dropped by the block
    task automatic load_settings(input setting_t s);
        write_reg(CFG_MIN_AVG, CFG_DATA_W'($urandom() << SIZE_W) | CFG_DATA_W'(s.min_avg));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom() << THR_W) | CFG_DATA_W'(s.threshold));
        write_reg(CFG_COOLDOWN, s.cooldown);
        write_reg(CFG_FORCE, s.force_ms);
        cfg_we <= 1'b0;
    endtask

    // offer one item, predict on acceptance, then maybe idle
    task automatic offer_item(input logic kind, input logic [SIZE_W-1:0] size,
                              input logic [TIME_W-1:0] now, input bit pinned,
                              input decision_t want);
        decision_t   d;
        int unsigned gap;
        frame_bus.valid      <= 1'b1;
        frame_bus.kind       <= kind;
        frame_bus.frame_size <= size;
        frame_bus.now_ms     <= now;
        do
        begin
            @(posedge clk);
        end
        while (frame_bus.ready !== 1'b1);
        if (kind == KIND_UPLOAD_DONE)
        begin
            last_upload = now;
            uploaded    = 1'b1;
            upload_told = 1'b0;
        end
        else
        begin
            d = judge_frame(size, now);
            owed.push_back(pinned ? want : d);
            upload_told = d.upload_now;
        end
        gap = sender_gap();
        if (gap != 0)
        begin
            frame_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait for every owed decision, then let an upload-done item settle
    task automatic drain();
        while (owed.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        probe_t            probes[$];
        setting_t          plan [PHASES];
        setting_t          s;
        logic [TIME_W-1:0] clock_ms;
        logic [SIZE_W-1:0] size;
        logic [31:0]       base;
        logic [31:0]       wide;
        logic              kind;
        int unsigned       roll;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_MIN_AVG;
        cfg_wdata              = '0;
        frame_bus.valid        = 1'b0;
        frame_bus.kind         = KIND_FRAME;
        frame_bus.frame_size   = '0;
        frame_bus.now_ms       = '0;
        decision_bus.ready     = 1'b0;
        mismatches             = 0;
        quiet                  = 1'b0;
        hold_off_req           = 1'b0;
        upload_told            = 1'b0;
        foreach (win_sizes[i])
            win_sizes[i] = '0;
        win_sum       = '0;
        win_fill      = 0;
        win_slot      = 0;
        last_upload   = '0;
        uploaded      = 1'b0;
        reg_min_avg   = MIN_AVG_RST;
        reg_threshold = THRESHOLD_RST;
        reg_cooldown  = COOLDOWN_RST;
        reg_force     = FORCE_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty and zero-sum window, wrap, cooldown and interval edges
        probes.push_back('{KIND_FRAME,       20'h00000, 32'h00000000, 1'b1, FIRST_ON_EMPTY});
        probes.push_back('{KIND_FRAME,       20'hFFFFF, 32'hFFFFFFFF, 1'b1, FIRST_ON_EMPTY});
        probes.push_back('{KIND_UPLOAD_DONE, 20'h00000, 32'hFFFFFFF0, 1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd1000,  32'd10,       1'b0, UNPINNED});
        for (int t = 20; t <= 60; t += 10)
            probes.push_back('{KIND_FRAME, 20'd2000, 32'(t), 1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd2000,  32'd100,      1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd4000,  32'd2000,     1'b0, UNPINNED});
        probes.push_back('{KIND_UPLOAD_DONE, 20'hABCDE, 32'd20000,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd2100,  32'd21999,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd2000,  32'd22000,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd2000,  32'd29999,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd2000,  32'd30000,    1'b0, UNPINNED});
        probes.push_back('{KIND_UPLOAD_DONE, 20'h00000, 32'd30000,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd0,     32'd30001,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'hFFFFF, 32'd30002,    1'b0, UNPINNED});
        probes.push_back('{KIND_FRAME,       20'd1,     32'd40001,    1'b0, UNPINNED});
        foreach (probes[i])
            offer_item(probes[i].kind, probes[i].size, probes[i].now, probes[i].pinned,
                       probes[i].want);
        frame_bus.valid <= 1'b0;
        drain();

        // random phases: register extremes, shuffled values, different traffic shapes
        plan[0] = '{MIN_AVG_RST, THRESHOLD_RST, COOLDOWN_RST, FORCE_RST, 1'b0, 1'b1, 1'b0,
                    SIZES_STEADY};
        plan[1] = '{20'd0, 16'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0, SIZES_ZERO};
        plan[2] = '{20'hFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0,
                    SIZES_ANY};
        plan[3] = '{20'd0, 16'd26, 32'd500, 32'd3000, 1'b0, 1'b0, 1'b0, SIZES_STEADY};
        plan[4] = '{20'd100, 16'd128, 32'd0, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, SIZES_SPIKY};
        plan[5] = '{20'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, SIZES_STEADY};
        plan[6] = '{20'd50000, 16'd300, 32'd1000, 32'd8000, 1'b0, 1'b1, 1'b1, SIZES_STEADY};
        plan[7] = '{20'd0, 16'd512, 32'hFFFFFFFF, 32'd5000, 1'b0, 1'b0, 1'b0, SIZES_SPIKY};
        plan[8] = '{20'd0, 16'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0, SIZES_ANY};
        plan[9] = '{20'd10, 16'd40, 32'd3000, 32'd0, 1'b0, 1'b0, 1'b0, SIZES_STEADY};

        clock_ms = 32'd50000;
        for (int p = 0; p < PHASES; p++)
        begin
            s = plan[p];
            if (s.shuffle)
            begin
                s.min_avg   = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom())
                                                          : SIZE_W'($urandom_range(0, 5000));
                s.threshold = THR_W'($urandom_range(0, 1024));
                s.cooldown  = $urandom_range(0, 20000);
                s.force_ms  = $urandom_range(0, 40000);
            end
            load_settings(s);
            quiet = s.quiet;
            base  = $urandom_range(500, 120000);
            if (s.hold)
                hold_off_req = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // time moves mostly forward in small steps, sometimes jumps anywhere
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    clock_ms += 32'($urandom_range(0, 300));
                else if (roll < 90)
                    clock_ms += 32'($urandom_range(300, 5000));
                else if (roll < 97)
                    clock_ms += 32'($urandom_range(5000, 20000));
                else
                    clock_ms = $urandom();

                // an upload decision is usually followed by its upload-done
                if (upload_told && $urandom_range(0, 99) < 70)
                    kind = KIND_UPLOAD_DONE;
                else if ($urandom_range(0, 99) < 4)
                    kind = KIND_UPLOAD_DONE;
                else
                    kind = KIND_FRAME;

                roll = $urandom_range(0, 99);
                case (s.mix)
                    SIZES_ZERO:
                        size = (roll < 85) ? '0 : SIZE_W'($urandom_range(0, 15));
                    SIZES_STEADY:
                    begin
                        wide = base + $urandom_range(0, base / 8 + 1);
                        if (roll < 6)
                            wide = base * 3;
                        else if (roll < 12)
                            wide = base / 4;
                        size = (wide > 32'hFFFFF) ? 20'hFFFFF : SIZE_W'(wide);
                    end
                    SIZES_SPIKY:
                        if (roll < 80)
                            size = SIZE_W'($urandom_range(1, 64));
                        else if (roll < 90)
                            size = 20'hFFFFF;
                        else
                            size = SIZE_W'($urandom());
                    default:
                        size = SIZE_W'($urandom());
                endcase
                offer_item(kind, size, clock_ms, 1'b0, UNPINNED);
            end
            frame_bus.valid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && owed.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_drain
        int unsigned stall;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stall != 0)
            begin
                decision_bus.ready <= 1'b0;
                stall--;
            end
            else if (hold_off_req)
            begin
                decision_bus.ready <= 1'b0;
                stall        = HOLD_CYCLES - 1;
                hold_off_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < 25)
            begin
                decision_bus.ready <= 1'b0;
                stall = idle_len() - 1;
            end
            else
                decision_bus.ready <= 1'b1;
        end
    end

    // compare each accepted decision with the oldest one owed
    always @(posedge clk)
    begin : decision_check
        decision_t got;
        decision_t want;
        if (rst_n === 1'b1 && decision_bus.valid === 1'b1 && decision_bus.ready === 1'b1)
        begin
            got = '{decision_bus.upload_now, decision_bus.reason_code,
                    decision_bus.average_size_q4, decision_bus.change_ratio_q8,
                    decision_bus.window_full, decision_bus.cooling_down,
                    decision_bus.change_triggered, decision_bus.interval_triggered};
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected decision item: %s", describe(got));
            end
            else
            begin
                want = owed.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("decision mismatch\n  expected %s\n  actual   %s",
                                 describe(want), describe(got));
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial cycles = 0;

endmodule
